>>> sv/mtbp_pkg.sv
// ============================================================================
// mtbp_pkg: shared types and constants for the MIDI track byte parser
// Parse phases, status and meta codes, the result item layout, and the
// piano key frequency table.
// ============================================================================
`default_nettype none

package mtbp_pkg;

    // Variable-length quantity limits
    localparam int QUANTITY_MAX_BYTES = 4;
    localparam int QV_W               = 7 * QUANTITY_MAX_BYTES;
    localparam int QCNT_W             = $clog2(QUANTITY_MAX_BYTES + 1);

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QC_W   = $clog2(QDEPTH + 1);

    // Tempo
    localparam int          TEMPO_W     = 24;
    localparam logic [23:0] TEMPO_RESET = 24'd500000;

    // Status bytes and command nibbles
    localparam logic [7:0] STATUS_META   = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
    localparam logic [7:0] STATUS_NONE   = 8'h00;
    localparam logic [3:0] CMD_NOTE_OFF  = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
    localparam logic [3:0] CMD_POLY_PRES = 4'hA;
    localparam logic [3:0] CMD_CONTROL   = 4'hB;
    localparam logic [3:0] CMD_PROGRAM   = 4'hC;
    localparam logic [3:0] CMD_CHAN_PRES = 4'hD;
    localparam logic [3:0] CMD_PITCH     = 4'hE;

    // Meta types
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] META_EOT   = 8'h2F;
    localparam logic [7:0] META_NONE  = 8'h00;

    // Playable key range and fixed note length
    localparam logic [7:0] NOTE_LOW     = 8'd21;
    localparam logic [7:0] NOTE_HIGH    = 8'd108;
    localparam logic [8:0] NOTE_LEN_MS  = 9'd300;
    localparam int         TEMPO_LEN    = 3;

    // Halt reasons
    localparam logic [1:0] HALT_RUN   = 2'd0;
    localparam logic [1:0] HALT_EOT   = 2'd1;
    localparam logic [1:0] HALT_FAULT = 2'd2;

    // Done status codes
    localparam logic [1:0] DONE_EOT      = 2'd0;
    localparam logic [1:0] DONE_BOUNDARY = 2'd1;
    localparam logic [1:0] DONE_BAD      = 2'd2;

    // Item kinds
    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [10:0] {
        PH_DELTA     = 11'b000_0000_0001,
        PH_STATUS    = 11'b000_0000_0010,
        PH_META_TYPE = 11'b000_0000_0100,
        PH_META_LEN  = 11'b000_0000_1000,
        PH_META_DATA = 11'b000_0001_0000,
        PH_SYSEX_LEN = 11'b000_0010_0000,
        PH_SYSEX_DAT = 11'b000_0100_0000,
        PH_ON_KEY    = 11'b000_1000_0000,
        PH_ON_VEL    = 11'b001_0000_0000,
        PH_OFF_DATA  = 11'b010_0000_0000,
        PH_CHAN_SKIP = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        phase_t     ph;
        logic [1:0] skip;
        logic       fault;
    } disp_t;

    typedef struct packed {
        logic                kind;
        logic [12:0]         hz;
        logic [8:0]          len_ms;
        logic [7:0]          vel;
        logic [1:0]          status;
        logic [TEMPO_W-1:0]  tempo;
        logic                last;
    } item_t;

    // Equal-tempered piano keys, A0 upward, rounded to hertz
    function automatic logic [12:0] piano_hz(input logic [6:0] key);
        logic [12:0] hz;
        begin
            case (key)
                7'd0:  hz = 13'd28;   7'd1:  hz = 13'd29;   7'd2:  hz = 13'd31;
                7'd3:  hz = 13'd33;   7'd4:  hz = 13'd35;   7'd5:  hz = 13'd37;
                7'd6:  hz = 13'd39;   7'd7:  hz = 13'd41;   7'd8:  hz = 13'd44;
                7'd9:  hz = 13'd46;   7'd10: hz = 13'd49;   7'd11: hz = 13'd52;
                7'd12: hz = 13'd55;   7'd13: hz = 13'd58;   7'd14: hz = 13'd62;
                7'd15: hz = 13'd65;   7'd16: hz = 13'd69;   7'd17: hz = 13'd73;
                7'd18: hz = 13'd78;   7'd19: hz = 13'd82;   7'd20: hz = 13'd87;
                7'd21: hz = 13'd92;   7'd22: hz = 13'd98;   7'd23: hz = 13'd104;
                7'd24: hz = 13'd110;  7'd25: hz = 13'd117;  7'd26: hz = 13'd123;
                7'd27: hz = 13'd131;  7'd28: hz = 13'd139;  7'd29: hz = 13'd147;
                7'd30: hz = 13'd156;  7'd31: hz = 13'd165;  7'd32: hz = 13'd175;
                7'd33: hz = 13'd185;  7'd34: hz = 13'd196;  7'd35: hz = 13'd208;
                7'd36: hz = 13'd220;  7'd37: hz = 13'd233;  7'd38: hz = 13'd247;
                7'd39: hz = 13'd262;  7'd40: hz = 13'd277;  7'd41: hz = 13'd294;
                7'd42: hz = 13'd311;  7'd43: hz = 13'd330;  7'd44: hz = 13'd349;
                7'd45: hz = 13'd370;  7'd46: hz = 13'd392;  7'd47: hz = 13'd415;
                7'd48: hz = 13'd440;  7'd49: hz = 13'd466;  7'd50: hz = 13'd494;
                7'd51: hz = 13'd523;  7'd52: hz = 13'd554;  7'd53: hz = 13'd587;
                7'd54: hz = 13'd622;  7'd55: hz = 13'd659;  7'd56: hz = 13'd698;
                7'd57: hz = 13'd740;  7'd58: hz = 13'd784;  7'd59: hz = 13'd831;
                7'd60: hz = 13'd880;  7'd61: hz = 13'd932;  7'd62: hz = 13'd988;
                7'd63: hz = 13'd1047; 7'd64: hz = 13'd1109; 7'd65: hz = 13'd1175;
                7'd66: hz = 13'd1245; 7'd67: hz = 13'd1319; 7'd68: hz = 13'd1397;
                7'd69: hz = 13'd1480; 7'd70: hz = 13'd1568; 7'd71: hz = 13'd1661;
                7'd72: hz = 13'd1760; 7'd73: hz = 13'd1865; 7'd74: hz = 13'd1976;
                7'd75: hz = 13'd2093; 7'd76: hz = 13'd2217; 7'd77: hz = 13'd2349;
                7'd78: hz = 13'd2489; 7'd79: hz = 13'd2637; 7'd80: hz = 13'd2794;
                7'd81: hz = 13'd2960; 7'd82: hz = 13'd3136; 7'd83: hz = 13'd3322;
                7'd84: hz = 13'd3520; 7'd85: hz = 13'd3729; 7'd86: hz = 13'd3951;
                7'd87: hz = 13'd4186;
                default: hz = 13'd0;
            endcase
            return hz;
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/midi_track_byte_parser.sv
// ============================================================================
// midi_track_byte_parser: one-byte-per-cycle MIDI track event decoder
// Path: accepted byte -> input stage register -> result queue -> output.
// Throughput: 1 byte per cycle while at most two of the 4 result queue
//   entries are full; a byte giving a note and a done item fills two.
// Reset: async active low; parser idle at delta, tempo 500000, queue empty.
// ============================================================================
`default_nettype none

// Structure
//   input stage : one register holding the accepted byte and its last flag.
//   parse logic : from the input stage and the parser state, a single pass
//                 computes the next state and up to two result items
//                 (note event, then track done).
//   result queue: 4 entries in fixed positions, head at entry 0, shifting on
//                 each pop. The input stage advances only while at most two
//                 entries are full, so both items of one byte always fit.
//
// Parsing details kept here in one pass:
//   - after four continuation bytes a quantity ends with value 0, and the
//     fifth byte is taken as the next field (or halts an end-of-track meta);
//   - a data byte where a status is due reuses the running status and is
//     taken as that message's first data byte;
//   - running status and tempo survive the end of a track, the rest of the
//     parser state returns to reset after each done item.

module midi_track_byte_parser
    import mtbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] track_byte
    input  wire logic        s_axis_tlast,   // final_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [12:0] pitch_hz, [21:13] length_ms, [29:22] strike_velocity,
    // [31:30] done_status, [55:32] tempo_us
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tuser,   // item_kind
    output logic             m_axis_tlast    // run_last
);

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_fin_reg;
    logic       adv;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t              phase_reg,  phase_next;
    logic [7:0]          rs_reg,     rs_next;
    logic [TEMPO_W-1:0]  tempo_reg,  tempo_next;
    logic [QCNT_W-1:0]   qcnt_reg,   qcnt_next;
    logic [QV_W-1:0]     qval_reg,   qval_next;
    logic [QV_W-1:0]     skip_reg,   skip_next;
    logic [7:0]          meta_reg,   meta_next;
    logic [7:0]          note_reg,   note_next;
    logic [TEMPO_W-1:0]  tshift_reg, tshift_next;
    logic [1:0]          halt_reg,   halt_next;

    // Per-item scratch
    logic                consumed;
    logic [QV_W-1:0]     qv_shift;
    disp_t               disp;
    logic                note_fire;
    logic [7:0]          note_off;
    logic [1:0]          done_code;
    item_t               it_note, it_done, it0;
    logic                w0, w1;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    item_t             q_reg  [QDEPTH];
    item_t             q_next [QDEPTH];
    logic [QC_W-1:0]   qc_reg, qc_next;
    logic [QC_W-1:0]   qbase;
    logic              pop;

    // Status decode: next phase and how many channel data bytes to drop
    function automatic disp_t dispatch_f(input logic [7:0] st);
        disp_t d;
        begin
            d.ph    = PH_CHAN_SKIP;
            d.skip  = 2'd0;
            d.fault = 1'b0;
            if (st == STATUS_META) begin
                d.ph = PH_META_TYPE;
            end
            else if (st == STATUS_SYSEX || st == STATUS_ESCAPE) begin
                d.ph = PH_SYSEX_LEN;
            end
            else begin
                case (st[7:4])
                    CMD_NOTE_ON:   d.ph = PH_ON_KEY;
                    CMD_NOTE_OFF:
                    begin
                        d.ph   = PH_OFF_DATA;
                        d.skip = 2'd2;
                    end
                    CMD_PROGRAM, CMD_CHAN_PRES:
                    begin
                        d.skip = 2'd1;
                    end
                    CMD_POLY_PRES, CMD_CONTROL, CMD_PITCH:
                    begin
                        d.skip = 2'd2;
                    end
                    default:       d.fault = 1'b1;   // system common / realtime
                endcase
            end
            return d;
        end
    endfunction

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign adv           = s1_valid_reg && (qc_reg <= QC_W'(QDEPTH - 2));
    assign s_axis_tready = !s1_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_fin_reg  <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Parse pass
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next  = phase_reg;
        rs_next     = rs_reg;
        tempo_next  = tempo_reg;
        qcnt_next   = qcnt_reg;
        qval_next   = qval_reg;
        skip_next   = skip_reg;
        meta_next   = meta_reg;
        note_next   = note_reg;
        tshift_next = tshift_reg;
        halt_next   = halt_reg;
        consumed    = 1'b0;
        qv_shift    = '0;
        disp        = dispatch_f(rs_reg);
        note_fire   = 1'b0;
        note_off    = note_reg - NOTE_LOW;
        done_code   = DONE_BOUNDARY;

        if (halt_reg == HALT_RUN)
        begin
            // Overlong quantity: close with zero, byte to the next field or EOT halt
            if ((phase_reg == PH_DELTA || phase_reg == PH_META_LEN ||
                 phase_reg == PH_SYSEX_LEN) &&
                qcnt_reg == QCNT_W'(QUANTITY_MAX_BYTES))
            begin
                qcnt_next = '0;
                qval_next = '0;
                case (phase_reg)
                    PH_DELTA:    phase_next = PH_STATUS;
                    PH_META_LEN:
                    begin
                        if (meta_reg == META_EOT)
                        begin
                            halt_next = HALT_EOT;
                            consumed  = 1'b1;
                        end
                        else
                        begin
                            if (meta_reg == META_TEMPO)
                            begin
                                meta_next = META_NONE;
                            end
                            phase_next = PH_DELTA;
                        end
                    end
                    default:     phase_next = PH_DELTA;
                endcase
            end

            // Status position, with running status fallback
            if (!consumed && phase_next == PH_STATUS)
            begin
                if (s1_byte_reg[7])
                begin
                    rs_next  = s1_byte_reg;
                    disp     = dispatch_f(s1_byte_reg);
                    consumed = 1'b1;
                end
                if (!s1_byte_reg[7] && rs_reg == STATUS_NONE)
                begin
                    halt_next = HALT_FAULT;
                    consumed  = 1'b1;
                end
                else if (disp.fault)
                begin
                    halt_next = HALT_FAULT;
                    consumed  = 1'b1;
                end
                else
                begin
                    phase_next = disp.ph;
                    skip_next  = QV_W'(disp.skip);
                end
            end

            if (!consumed)
            begin
                case (phase_next)
                    PH_DELTA, PH_META_LEN, PH_SYSEX_LEN:
                    begin
                        qv_shift  = QV_W'({qval_next, s1_byte_reg[6:0]});
                        qval_next = qv_shift;
                        qcnt_next = qcnt_next + QCNT_W'(1);
                        if (!s1_byte_reg[7])
                        begin
                            qcnt_next = '0;
                            qval_next = '0;
                            case (phase_next)
                                PH_DELTA:    phase_next = PH_STATUS;
                                PH_META_LEN:
                                begin
                                    // tempo meta only counts with exactly three bytes
                                    if (meta_next == META_TEMPO &&
                                        qv_shift != QV_W'(TEMPO_LEN))
                                    begin
                                        meta_next = META_NONE;
                                    end
                                    if (qv_shift == '0)
                                    begin
                                        if (meta_next == META_EOT)
                                        begin
                                            halt_next = HALT_EOT;
                                        end
                                        else
                                        begin
                                            phase_next = PH_DELTA;
                                        end
                                    end
                                    else
                                    begin
                                        skip_next   = qv_shift;
                                        tshift_next = '0;
                                        phase_next  = PH_META_DATA;
                                    end
                                end
                                default:
                                begin
                                    if (qv_shift == '0)
                                    begin
                                        phase_next = PH_DELTA;
                                    end
                                    else
                                    begin
                                        skip_next  = qv_shift;
                                        phase_next = PH_SYSEX_DAT;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_META_TYPE:
                    begin
                        meta_next  = s1_byte_reg;
                        phase_next = PH_META_LEN;
                    end
                    PH_META_DATA:
                    begin
                        if (meta_next == META_TEMPO)
                        begin
                            tshift_next = {tshift_reg[TEMPO_W-9:0], s1_byte_reg};
                        end
                        if (skip_next != '0)
                        begin
                            skip_next = skip_next - QV_W'(1);
                        end
                        if (skip_next == '0)
                        begin
                            if (meta_next == META_TEMPO)
                            begin
                                tempo_next = tshift_next;
                            end
                            if (meta_next == META_EOT)
                            begin
                                halt_next = HALT_EOT;
                            end
                            else
                            begin
                                phase_next = PH_DELTA;
                            end
                        end
                    end
                    PH_ON_KEY:
                    begin
                        note_next  = s1_byte_reg;
                        phase_next = PH_ON_VEL;
                    end
                    PH_ON_VEL:
                    begin
                        note_fire  = (s1_byte_reg != 8'd0) && (note_reg >= NOTE_LOW) &&
                                     (note_reg <= NOTE_HIGH);
                        phase_next = PH_DELTA;
                    end
                    default:   // SysEx data, note-off data, channel skip
                    begin
                        if (skip_next != '0)
                        begin
                            skip_next = skip_next - QV_W'(1);
                        end
                        if (skip_next == '0)
                        begin
                            phase_next = PH_DELTA;
                        end
                    end
                endcase
            end
        end

        // Ending status from where this byte leaves the parser
        if (halt_next == HALT_EOT)
        begin
            done_code = DONE_EOT;
        end
        else if (halt_next != HALT_RUN)
        begin
            done_code = DONE_BAD;
        end
        else
        begin
            case (phase_next)
                PH_META_TYPE, PH_META_DATA, PH_SYSEX_DAT,
                PH_ON_KEY, PH_ON_VEL, PH_OFF_DATA:
                begin
                    done_code = DONE_BAD;
                end
                PH_META_LEN:
                begin
                    done_code = (meta_next == META_EOT) ? DONE_EOT : DONE_BOUNDARY;
                end
                default:   done_code = DONE_BOUNDARY;
            endcase
        end

        // Last byte: start the next track clean, keep running status and tempo
        if (s1_fin_reg)
        begin
            phase_next  = PH_DELTA;
            qcnt_next   = '0;
            qval_next   = '0;
            skip_next   = '0;
            meta_next   = META_NONE;
            note_next   = 8'd0;
            tshift_next = '0;
            halt_next   = HALT_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DELTA;
            rs_reg     <= STATUS_NONE;
            tempo_reg  <= TEMPO_RESET;
            qcnt_reg   <= '0;
            qval_reg   <= '0;
            skip_reg   <= '0;
            meta_reg   <= META_NONE;
            note_reg   <= 8'd0;
            tshift_reg <= '0;
            halt_reg   <= HALT_RUN;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            rs_reg     <= rs_next;
            tempo_reg  <= tempo_next;
            qcnt_reg   <= qcnt_next;
            qval_reg   <= qval_next;
            skip_reg   <= skip_next;
            meta_reg   <= meta_next;
            note_reg   <= note_next;
            tshift_reg <= tshift_next;
            halt_reg   <= halt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result items: note first, done item last
    // ------------------------------------------------------------------
    always_comb
    begin
        it_note.kind   = KIND_NOTE;
        it_note.hz     = piano_hz(note_off[6:0]);
        it_note.len_ms = NOTE_LEN_MS;
        it_note.vel    = s1_byte_reg;
        it_note.status = DONE_EOT;
        it_note.tempo  = tempo_next;
        it_note.last   = !s1_fin_reg;

        it_done.kind   = KIND_DONE;
        it_done.hz     = '0;
        it_done.len_ms = '0;
        it_done.vel    = '0;
        it_done.status = done_code;
        it_done.tempo  = tempo_next;
        it_done.last   = 1'b1;

        it0 = note_fire ? it_note : it_done;
        w0  = adv && (note_fire || s1_fin_reg);
        w1  = adv && note_fire && s1_fin_reg;
    end

    // ------------------------------------------------------------------
    // Result queue: shift on pop, append behind the last full entry
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < QDEPTH - 1; i++)
        begin
            q_next[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        q_next[QDEPTH-1] = q_reg[QDEPTH-1];

        qbase = qc_reg - QC_W'(pop);
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (w0 && qbase == QC_W'(i))
            begin
                q_next[i] = it0;
            end
            if (w1 && qbase + QC_W'(1) == QC_W'(i))
            begin
                q_next[i] = it_done;
            end
        end

        qc_next = qbase + QC_W'(w0) + QC_W'(w1);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qc_reg <= '0;
        end
        else
        begin
            qc_reg <= qc_next;
        end
    end

    assign m_axis_tvalid = (qc_reg != '0);
    assign m_axis_tuser  = q_reg[0].kind;
    assign m_axis_tlast  = q_reg[0].last;
    assign m_axis_tdata  = {q_reg[0].tempo, q_reg[0].status, q_reg[0].vel,
                            q_reg[0].len_ms, q_reg[0].hz};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qc_reg <= QC_W'(QDEPTH))
        else $error("result queue count above depth");

    a_track_reset: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_fin_reg |=> phase_reg == PH_DELTA && halt_reg == HALT_RUN &&
                             qcnt_reg == '0)
        else $error("parser not cleared after last byte");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_DONE |-> m_axis_tlast)
        else $error("done item without run_last");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        adv && halt_reg != HALT_RUN |-> !note_fire)
        else $error("note emitted while halted");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ============================================================================
// testbench: self-checking bench for midi_track_byte_parser
// Feeds MIDI track bytes through the input stream, predicts the note and
// track-done items in a behavioral parser kept here, and checks every output
// item field by field. Directed tracks first, then random well-formed tracks
// mixed with truncated, malformed and noisy ones.
// ============================================================================
`default_nettype none

module testbench;
    import mtbp_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset, block ports
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] track_byte
    logic        s_axis_tlast = 1'b0;    // final_byte

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [12:0] pitch_hz, [21:13] length_ms, [29:22] strike_velocity,
    // [31:30] done_status, [55:32] tempo_us
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;           // item_kind
    logic        m_axis_tlast;           // run_last

    midi_track_byte_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    item_t      pending_items[$];   // items the parser still owes us, oldest first
    int         mismatch_count = 0;
    int         bytes_sent = 0;
    bit         send_gaps = 1'b1;   // random pauses on the input side
    bit         sink_stalls = 1'b1; // random backpressure on the output side
    logic [7:0] track_bytes[$];     // track being built / sent
    logic [7:0] gen_status = 8'h00; // last status the generator wrote

    // ------------------------------------------------------------------
    // Predictor state: mirrors the parser, one byte at a time
    // ------------------------------------------------------------------
    phase_t      phase;
    logic [7:0]  run_status;
    logic [23:0] tempo_now;
    logic [2:0]  vlq_count;
    logic [27:0] vlq_value;
    logic [27:0] bytes_left;
    logic [7:0]  meta_code;
    logic [7:0]  key_held;
    logic [23:0] tempo_acc;
    logic [1:0]  halt_code;

    // Per-track fields go back to idle after each done item; running status
    // and tempo survive.
    function automatic void clear_track_state();
        phase      = PH_DELTA;
        vlq_count  = '0;
        vlq_value  = '0;
        bytes_left = '0;
        meta_code  = META_NONE;
        key_held   = '0;
        tempo_acc  = '0;
        halt_code  = HALT_RUN;
    endfunction

    // Equal-tempered frequency of a piano key, rounded to the nearest hertz
    function automatic logic [12:0] key_freq(input logic [7:0] key);
        int  idx;
        real hz;
        idx = int'(key) - int'(NOTE_LOW);
        hz  = 440.0 * (2.0 ** ((idx - 48) / 12.0));
        return 13'($rtoi(hz + 0.5));
    endfunction

    // A variable-length quantity just completed with value v
    function automatic void close_quantity(input logic [27:0] v);
        vlq_count = '0;
        vlq_value = '0;
        if (phase == PH_DELTA) begin
            phase = PH_STATUS;
        end
        else if (phase == PH_META_LEN) begin
            // a tempo meta of the wrong size is treated as an unknown meta
            if (meta_code == META_TEMPO && v != TEMPO_LEN)
                meta_code = META_NONE;
            if (v == 0) begin
                if (meta_code == META_EOT)
                    halt_code = HALT_EOT;
                else
                    phase = PH_DELTA;
            end
            else begin
                bytes_left = v;
                tempo_acc  = '0;
                phase      = PH_META_DATA;
            end
        end
        else begin
            if (v == 0) begin
                phase = PH_DELTA;
            end
            else begin
                bytes_left = v;
                phase      = PH_SYSEX_DAT;
            end
        end
    endfunction

    // Pick the phase that follows a status byte
    function automatic void route_status(input logic [7:0] st);
        if (st == STATUS_META) begin
            phase = PH_META_TYPE;
        end
        else if (st == STATUS_SYSEX || st == STATUS_ESCAPE) begin
            phase = PH_SYSEX_LEN;
        end
        else begin
            case (st[7:4])
                CMD_NOTE_ON: phase = PH_ON_KEY;
                CMD_NOTE_OFF:
                begin
                    bytes_left = 28'd2;
                    phase      = PH_OFF_DATA;
                end
                CMD_PROGRAM, CMD_CHAN_PRES:
                begin
                    bytes_left = 28'd1;
                    phase      = PH_CHAN_SKIP;
                end
                CMD_POLY_PRES, CMD_CONTROL, CMD_PITCH:
                begin
                    bytes_left = 28'd2;
                    phase      = PH_CHAN_SKIP;
                end
                default: halt_code = HALT_FAULT;   // system common / realtime
            endcase
        end
    endfunction

    function automatic logic [1:0] track_end_status();
        if (halt_code == HALT_EOT)
            return DONE_EOT;
        if (halt_code != HALT_RUN)
            return DONE_BAD;
        case (phase)
            PH_META_TYPE, PH_META_DATA, PH_SYSEX_DAT,
            PH_ON_KEY, PH_ON_VEL, PH_OFF_DATA:
                return DONE_BAD;
            PH_META_LEN:
                return (meta_code == META_EOT) ? DONE_EOT : DONE_BOUNDARY;
            default:
                return DONE_BOUNDARY;
        endcase
    endfunction

    // Advance the predictor by one accepted byte and queue what it causes
    task automatic predict_byte(input logic [7:0] b, input logic fin);
        item_t note;
        item_t done;
        bit    have_note;
        bit    reread;
        int    pass;
        have_note = 1'b0;
        note      = '0;
        if (halt_code == HALT_RUN) begin
            reread = 1'b1;
            // a byte can be looked at again (overlong quantity, running status)
            for (pass = 0; pass < 6 && reread && halt_code == HALT_RUN; pass++) begin
                reread = 1'b0;
                case (phase)
                    PH_DELTA, PH_META_LEN, PH_SYSEX_LEN:
                    begin
                        if (vlq_count >= QUANTITY_MAX_BYTES) begin
                            close_quantity('0);
                            reread = 1'b1;
                        end
                        else begin
                            vlq_value = {vlq_value[20:0], b[6:0]};
                            vlq_count = vlq_count + 3'd1;
                            if (!b[7])
                                close_quantity(vlq_value);
                        end
                    end
                    PH_STATUS:
                    begin
                        if (!b[7]) begin
                            if (run_status == STATUS_NONE) begin
                                halt_code = HALT_FAULT;
                            end
                            else begin
                                route_status(run_status);
                                reread = 1'b1;
                            end
                        end
                        else begin
                            run_status = b;
                            route_status(b);
                        end
                    end
                    PH_META_TYPE:
                    begin
                        meta_code = b;
                        phase     = PH_META_LEN;
                    end
                    PH_META_DATA:
                    begin
                        if (meta_code == META_TEMPO)
                            tempo_acc = {tempo_acc[15:0], b};
                        if (bytes_left > 0)
                            bytes_left = bytes_left - 28'd1;
                        if (bytes_left == 0) begin
                            if (meta_code == META_TEMPO)
                                tempo_now = tempo_acc;
                            if (meta_code == META_EOT)
                                halt_code = HALT_EOT;
                            else
                                phase = PH_DELTA;
                        end
                    end
                    PH_ON_KEY:
                    begin
                        key_held = b;
                        phase    = PH_ON_VEL;
                    end
                    PH_ON_VEL:
                    begin
                        if (b != 0 && key_held >= NOTE_LOW && key_held <= NOTE_HIGH) begin
                            note.kind   = KIND_NOTE;
                            note.hz     = key_freq(key_held);
                            note.len_ms = NOTE_LEN_MS;
                            note.vel    = b;
                            note.status = 2'd0;
                            note.tempo  = tempo_now;
                            note.last   = 1'b0;
                            have_note   = 1'b1;
                        end
                        phase = PH_DELTA;
                    end
                    default:
                    begin
                        // SysEx data, note-off data, other channel messages
                        if (bytes_left > 0)
                            bytes_left = bytes_left - 28'd1;
                        if (bytes_left == 0)
                            phase = PH_DELTA;
                    end
                endcase
            end
        end
        if (have_note) begin
            note.last = !fin;
            pending_items.push_back(note);
        end
        if (fin) begin
            done        = '0;
            done.kind   = KIND_DONE;
            done.status = track_end_status();
            done.tempo  = tempo_now;
            done.last   = 1'b1;
            pending_items.push_back(done);
            clear_track_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offers one byte and returns at the edge where it was taken. tvalid is
    // left high so back-to-back bytes follow without a gap.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (send_gaps && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_track();
        int i;
        for (i = 0; i < track_bytes.size(); i++)
            send_byte(track_bytes[i], i == track_bytes.size() - 1);
    endtask

    // Stop offering and hold off until the parser has delivered everything
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_items.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure, then field-by-field checking
    // ------------------------------------------------------------------
    initial begin
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_items.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual kind %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end
            else begin
                want = pending_items.pop_front();
                check_field("item_kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("pitch_hz", 32'(want.hz), 32'(m_axis_tdata[12:0]));
                check_field("length_ms", 32'(want.len_ms), 32'(m_axis_tdata[21:13]));
                check_field("strike_velocity", 32'(want.vel), 32'(m_axis_tdata[29:22]));
                check_field("done_status", 32'(want.status), 32'(m_axis_tdata[31:30]));
                check_field("tempo_us", 32'(want.tempo), 32'(m_axis_tdata[55:32]));
                check_field("run_last", 32'(want.last), 32'(m_axis_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random track generation
    // ------------------------------------------------------------------
    // n-byte variable-length quantity, continuation bit on all but the last
    task automatic add_vlq(input int unsigned v, input int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            track_bytes.push_back(8'((v >> (7 * i)) & 32'h7F) | ((i > 0) ? 8'h80 : 8'h00));
    endtask

    // four continuation bytes: the next byte ends the quantity with value 0
    task automatic add_overlong();
        repeat (4) track_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
    endtask

    task automatic add_delta();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            add_vlq($urandom_range(0, 127), 1);
        end
        else if (r < 95) begin
            n = $urandom_range(2, 4);
            add_vlq($urandom & ((32'd1 << (7 * n)) - 1), n);
        end
        else begin
            add_overlong();
        end
    endtask

    task automatic add_length(input int unsigned v);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            add_vlq(v, 1);
        else if (r < 95)
            add_vlq(v, 2);   // padded with a leading zero group
        else
            add_overlong();
    endtask

    function automatic logic [7:0] data_byte();
        if ($urandom_range(0, 19) == 0)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    // Status byte, dropped now and then when running status allows it
    task automatic add_channel_status(input logic [3:0] cmd);
        logic [7:0] st;
        st = {cmd, 4'($urandom_range(0, 15))};
        if (gen_status[7:4] == cmd && $urandom_range(0, 1) == 0)
            return;
        track_bytes.push_back(st);
        gen_status = st;
    endtask

    // One event after its delta; returns 1 when the event ends the track
    task automatic add_event(output bit track_over);
        int r;
        int len;
        int i;
        logic [7:0] st;
        track_over = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            add_channel_status(CMD_NOTE_ON);
            if ($urandom_range(0, 9) < 7)
                track_bytes.push_back(8'($urandom_range(NOTE_LOW, NOTE_HIGH)));
            else
                track_bytes.push_back(8'($urandom_range(0, 127)));
            if ($urandom_range(0, 9) == 0)
                track_bytes.push_back(8'h00);
            else if ($urandom_range(0, 19) == 0)
                track_bytes.push_back(8'($urandom_range(128, 255)));
            else
                track_bytes.push_back(8'($urandom_range(1, 127)));
        end
        else if (r < 38) begin
            add_channel_status(CMD_NOTE_OFF);
            repeat (2) track_bytes.push_back(data_byte());
        end
        else if (r < 44) begin
            add_channel_status($urandom_range(0, 1) ? CMD_PROGRAM : CMD_CHAN_PRES);
            track_bytes.push_back(data_byte());
        end
        else if (r < 50) begin
            case ($urandom_range(0, 2))
                0: add_channel_status(CMD_POLY_PRES);
                1: add_channel_status(CMD_CONTROL);
                default: add_channel_status(CMD_PITCH);
            endcase
            repeat (2) track_bytes.push_back(data_byte());
        end
        else if (r < 58) begin
            st = $urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE;
            track_bytes.push_back(st);
            gen_status = st;
            len = $urandom_range(0, 6);
            add_length(len);
            for (i = 0; i < len; i++)
                track_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 68) begin
            // tempo meta; sometimes with a wrong length
            track_bytes.push_back(STATUS_META);
            gen_status = STATUS_META;
            track_bytes.push_back(META_TEMPO);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : TEMPO_LEN;
            add_length(len);
            for (i = 0; i < len; i++)
                track_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 78) begin
            track_bytes.push_back(STATUS_META);
            gen_status = STATUS_META;
            track_bytes.push_back(8'($urandom_range(0, 127)));
            len = $urandom_range(0, 4);
            add_length(len);
            for (i = 0; i < len; i++)
                track_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 84) begin
            track_bytes.push_back(STATUS_META);
            gen_status = STATUS_META;
            track_bytes.push_back(META_EOT);
            track_bytes.push_back(8'h00);
            track_over = 1'b1;
        end
        else if (r < 88) begin
            // system common / realtime codes the parser does not accept
            if ($urandom_range(0, 1))
                st = 8'($urandom_range(8'hF1, 8'hF6));
            else
                st = 8'($urandom_range(8'hF8, 8'hFE));
            track_bytes.push_back(st);
            gen_status = st;
        end
        else if (r < 94) begin
            // data where a status is due, whatever the running status is
            repeat ($urandom_range(1, 2)) track_bytes.push_back(8'($urandom_range(0, 127)));
        end
        else begin
            repeat ($urandom_range(1, 3)) track_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_random_track();
        int  n_events;
        int  e;
        int  cut;
        bit  over;
        track_bytes.delete();
        n_events = $urandom_range(1, 8);
        over = 1'b0;
        for (e = 0; e < n_events && !over; e++) begin
            add_delta();
            add_event(over);
        end
        if (over) begin
            // a few bytes after end-of-track are ignored
            repeat ($urandom_range(0, 2)) track_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if ($urandom_range(0, 6) == 0 && track_bytes.size() > 1) begin
            cut = $urandom_range(1, (track_bytes.size() > 3) ? 3 : track_bytes.size() - 1);
            repeat (cut) void'(track_bytes.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Right after reset no running status exists: a data byte in the status
    // position is a fault.
    task automatic test_missing_running_status();
        track_bytes = '{8'h00, 8'h40};
        send_track();
        drain_results();
    endtask

    // Lowest key at velocity 0xFF, highest key at velocity 1 by running
    // status, then end-of-track meta.
    task automatic test_note_range_and_eot();
        track_bytes = '{8'h00, 8'h90, NOTE_LOW, 8'hFF,
                        8'h00, NOTE_HIGH, 8'h01,
                        8'h00, STATUS_META, META_EOT, 8'h00};
        send_track();
        drain_results();
    endtask

    // Overlong delta whose fifth byte is the meta status, tempo set to all
    // ones, then an unknown status.
    task automatic test_tempo_overlong_unknown();
        track_bytes = '{8'h80, 8'h80, 8'h80, 8'h80,
                        STATUS_META, META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                        8'h00, 8'hF3};
        send_track();
        drain_results();
    endtask

    task automatic test_random_tracks();
        int stop_at;
        stop_at = bytes_sent + 1750;
        while (bytes_sent < stop_at) begin
            // last stretch runs at full rate on both sides
            if (bytes_sent > stop_at - 250) begin
                send_gaps   = 1'b0;
                sink_stalls = 1'b0;
            end
            build_random_track();
            send_track();
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        clear_track_state();
        run_status = STATUS_NONE;
        tempo_now  = TEMPO_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_missing_running_status();
        test_note_range_and_eot();
        test_tempo_overlong_unknown();
        test_random_tracks();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_items.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
